>>> rtl/direct_mapped_writeback_cache_core_defines.svh
// Assertion macros shared by the cache core modules.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_CORE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DMWC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DMWC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dmwc_pkg.sv
// Shared constants, request kinds and controller/datapath interface types.
`timescale 1ns / 1ps
package dmwc_pkg;

  localparam int unsigned NumLinesDef        = 256;
  localparam int unsigned BlockBytesDef      = 64;
  localparam int unsigned BackingAddrBitsDef = 20;
  localparam int unsigned WordBytes          = 4;

  localparam int unsigned KindW    = 2;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned WordW    = 32;
  localparam int unsigned LatW     = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned OutDataW = 72;

  // Request kinds.
  localparam logic [KindW-1:0] KIND_READ  = 2'd0;
  localparam logic [KindW-1:0] KIND_WRITE = 2'd1;
  localparam logic [KindW-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KindW-1:0] KIND_INVAL = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_BK_RD_LAT = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_BK_WR_LAT = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_C_RD_LAT  = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_C_WR_LAT  = 8'd3;

  localparam logic [LatW-1:0] BkRdLatRst = 16'd100;
  localparam logic [LatW-1:0] BkWrLatRst = 16'd50;
  localparam logic [LatW-1:0] CRdLatRst  = 16'd1;
  localparam logic [LatW-1:0] CWrLatRst  = 16'd1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_req;
    logic clr_time;
    logic inval_all;
    logic hit_load;
    logic cnt_clr;
    logic cnt_inc;
    logic wb_rd;
    logic wb_wr;
    logic rf_rd;
    logic rf_wr;
    logic tag_wr;
    logic acc_rd;
    logic acc_wr;
    logic add_bk_wr;
    logic add_bk_rd;
    logic add_c_rd;
    logic add_c_wr;
    logic set_evict;
    logic out_load;
  } dmwc_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             addr_err;
    logic             hit;
    logic             victim_dirty;
    logic             cnt_last;
    logic             clear_busy;
    logic             out_busy;
  } dmwc_sts_t;

endpackage

>>> rtl/direct_mapped_writeback_cache_core.sv
// A hit goes from request to result through lookup, check and access; a refill
// miss also moves the block word by word, after a write-back of a dirty line.
// Throughput: one request at a time; block moves alternate a read and a write of
// each word through the data and backing memories.
// Reset: rst_n synchronous; after it a clearing pass zeroes all 2^(BACKING_ADDR_BITS-2)
// words of the backing memory before the first request is taken.
`timescale 1ns / 1ps
module direct_mapped_writeback_cache_core
  import dmwc_pkg::*;
#(
  parameter int unsigned NUM_LINES         = NumLinesDef,
  parameter int unsigned BLOCK_BYTES       = BlockBytesDef,
  parameter int unsigned BACKING_ADDR_BITS = BackingAddrBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [31:0] byte_address, [63:32] write_word
  input  logic [63:0]         in_tdata,
  // [1:0] kind
  input  logic [KindW-1:0]    in_tuser,
  input  logic                out_tready,
  output logic                out_tvalid,
  // [31:0] read_word, [32] hit, [33] evicted_dirty, [34] address_error,
  // [66:35] elapsed_time, [71:67] zero
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [LatW-1:0]     cfg_data
);

  dmwc_cmd_t cmd;
  dmwc_sts_t sts;

  assign cfg_ready = 1'b1;

  dmwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dmwc_dp #(
    .NUM_LINES         (NUM_LINES),
    .BLOCK_BYTES       (BLOCK_BYTES),
    .BACKING_ADDR_BITS (BACKING_ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_kind    (in_tuser),
    .in_addr    (in_tdata[31:0]),
    .in_wdata   (in_tdata[63:32]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/dmwc_ctrl.sv
// Controller state machine sequencing lookup, write-back, refill and access.
`timescale 1ns / 1ps
`include "direct_mapped_writeback_cache_core_defines.svh"
module dmwc_ctrl
  import dmwc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dmwc_sts_t sts,
  output dmwc_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOKUP, ST_CHECK, ST_WB_RD, ST_WB_WR,
    ST_RF_RD, ST_RF_WR, ST_ACC, ST_RESP
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE) && !sts.clear_busy;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts.kind == KIND_CLEAR) begin
          cmd.clr_time = 1'b1;
          state_nxt    = ST_RESP;
        end else if (sts.kind == KIND_INVAL) begin
          cmd.inval_all = 1'b1;
          state_nxt     = ST_RESP;
        end else if (sts.addr_err) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.hit_load = 1'b1;
        cmd.cnt_clr  = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_ACC;
        end else if (sts.victim_dirty) begin
          cmd.set_evict = 1'b1;
          cmd.add_bk_wr = 1'b1;
          state_nxt     = ST_WB_RD;
        end else begin
          state_nxt = ST_RF_RD;
        end
      end
      ST_WB_RD: begin
        cmd.wb_rd = 1'b1;
        state_nxt = ST_WB_WR;
      end
      ST_WB_WR: begin
        cmd.wb_wr = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_RF_RD;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = ST_WB_RD;
        end
      end
      ST_RF_RD: begin
        cmd.rf_rd = 1'b1;
        state_nxt = ST_RF_WR;
      end
      ST_RF_WR: begin
        cmd.rf_wr = 1'b1;
        if (sts.cnt_last) begin
          cmd.tag_wr    = 1'b1;
          cmd.add_bk_rd = 1'b1;
          state_nxt     = ST_ACC;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = ST_RF_RD;
        end
      end
      ST_ACC: begin
        if (sts.kind == KIND_READ) begin
          cmd.acc_rd   = 1'b1;
          cmd.add_c_rd = 1'b1;
        end else begin
          cmd.acc_wr   = 1'b1;
          cmd.add_c_wr = 1'b1;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `DMWC_ASSERT_NXT(a_wb_to_refill, (state_r == ST_WB_WR) && sts.cnt_last, state_r == ST_RF_RD, "write-back did not continue into refill")
  `DMWC_ASSERT_IMP(a_no_accept_busy, cmd.load_req, !sts.clear_busy, "request taken during clearing pass")
  `DMWC_ASSERT_NXT(a_resp_done, cmd.out_load, state_r == ST_IDLE, "controller did not return to idle after the result")

endmodule

>>> rtl/dmwc_dp.sv
// Datapath: request registers, line state, tag/data/backing memories, timing total.
`timescale 1ns / 1ps
`include "direct_mapped_writeback_cache_core_defines.svh"
module dmwc_dp
  import dmwc_pkg::*;
#(
  parameter int unsigned NUM_LINES         = NumLinesDef,
  parameter int unsigned BLOCK_BYTES       = BlockBytesDef,
  parameter int unsigned BACKING_ADDR_BITS = BackingAddrBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [KindW-1:0]    in_kind,
  input  logic [AddrW-1:0]    in_addr,
  input  logic [WordW-1:0]    in_wdata,
  input  logic                cfg_valid,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [LatW-1:0]     cfg_data,
  input  dmwc_cmd_t           cmd,
  output dmwc_sts_t           sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata
);

  localparam int unsigned OffW   = $clog2(BLOCK_BYTES);
  localparam int unsigned IdxW   = $clog2(NUM_LINES);
  localparam int unsigned CntW   = OffW - 2;
  localparam int unsigned TagW   = BACKING_ADDR_BITS - OffW - IdxW;
  localparam int unsigned DAddrW = IdxW + CntW;
  localparam int unsigned BkW    = BACKING_ADDR_BITS - 2;
  localparam int unsigned DDepth = NUM_LINES * (BLOCK_BYTES / WordBytes);
  localparam int unsigned BkDepth = 1 << BkW;

  logic [KindW-1:0] kind_r;
  logic [AddrW-1:0] addr_r;
  logic [WordW-1:0] wdata_r;

  logic [IdxW-1:0] idx;
  logic [TagW-1:0] tag;
  logic [CntW-1:0] woff;
  logic            addr_err;

  assign idx      = addr_r[OffW +: IdxW];
  assign tag      = addr_r[OffW+IdxW +: TagW];
  assign woff     = addr_r[2 +: CntW];
  assign addr_err = |(({32'd0, addr_r} >> BACKING_ADDR_BITS));

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_r  <= in_kind;
      addr_r  <= in_addr;
      wdata_r <= in_wdata;
    end
  end

  // Latency registers.
  logic [LatW-1:0] bk_rd_lat_r, bk_wr_lat_r, c_rd_lat_r, c_wr_lat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_rd_lat_r <= BkRdLatRst;
      bk_wr_lat_r <= BkWrLatRst;
      c_rd_lat_r  <= CRdLatRst;
      c_wr_lat_r  <= CWrLatRst;
    end else if (cfg_valid) begin
      if (cfg_index == REG_BK_RD_LAT) bk_rd_lat_r <= cfg_data;
      if (cfg_index == REG_BK_WR_LAT) bk_wr_lat_r <= cfg_data;
      if (cfg_index == REG_C_RD_LAT)  c_rd_lat_r  <= cfg_data;
      if (cfg_index == REG_C_WR_LAT)  c_wr_lat_r  <= cfg_data;
    end
  end

  // Line valid and dirty bits.
  logic [NUM_LINES-1:0] valid_r, dirty_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.inval_all) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else begin
      if (cmd.tag_wr) begin
        valid_r[idx] <= 1'b1;
        dirty_r[idx] <= 1'b0;
      end
      if (cmd.acc_wr) begin
        dirty_r[idx] <= 1'b1;
      end
    end
  end

  // Tag store, read continuously at the request index.
  logic [TagW-1:0] tag_mem [NUM_LINES];
  logic [TagW-1:0] tag_q_r;
  always_ff @(posedge clk) begin
    if (cmd.tag_wr) begin
      tag_mem[idx] <= tag;
    end
    tag_q_r <= tag_mem[idx];
  end

  // Word counter for block moves.
  logic [CntW-1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Data store.
  logic [WordW-1:0]  data_mem [DDepth];
  logic [WordW-1:0]  data_q_r;
  logic [WordW-1:0]  bk_q_r;
  logic [DAddrW-1:0] d_raddr, d_waddr;
  logic [WordW-1:0]  d_wdata;

  assign d_raddr = cmd.acc_rd ? {idx, woff} : {idx, cnt_r};
  assign d_waddr = cmd.acc_wr ? {idx, woff} : {idx, cnt_r};
  assign d_wdata = cmd.acc_wr ? wdata_r : bk_q_r;

  always_ff @(posedge clk) begin
    if (cmd.rf_wr || cmd.acc_wr) begin
      data_mem[d_waddr] <= d_wdata;
    end
    if (cmd.wb_rd || cmd.acc_rd) begin
      data_q_r <= data_mem[d_raddr];
    end
  end

  // Clearing pass over the backing memory after reset.
  logic           clr_busy_r;
  logic [BkW-1:0] clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (&clr_cnt_r) clr_busy_r <= 1'b0;
    end
  end

  // Backing memory.
  logic [WordW-1:0] bk_mem [BkDepth];
  logic [BkW-1:0]   bk_waddr;
  logic [WordW-1:0] bk_wdata;

  assign bk_waddr = clr_busy_r ? clr_cnt_r : {tag_q_r, idx, cnt_r};
  assign bk_wdata = clr_busy_r ? '0 : data_q_r;

  always_ff @(posedge clk) begin
    if (clr_busy_r || cmd.wb_wr) begin
      bk_mem[bk_waddr] <= bk_wdata;
    end
    if (cmd.rf_rd) begin
      bk_q_r <= bk_mem[{tag, idx, cnt_r}];
    end
  end

  // Hit and eviction flags of the current request.
  logic hit_r, evict_r;
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      hit_r   <= 1'b0;
      evict_r <= 1'b0;
    end else begin
      if (cmd.hit_load)  hit_r   <= sts.hit;
      if (cmd.set_evict) evict_r <= 1'b1;
    end
  end

  // Running time total: at most one latency is added per cycle.
  logic [WordW-1:0] time_r, time_nxt;
  logic [LatW-1:0]  add_val;
  always_comb begin
    priority if (cmd.add_bk_wr) add_val = bk_wr_lat_r;
    else if (cmd.add_bk_rd)     add_val = bk_rd_lat_r;
    else if (cmd.add_c_rd)      add_val = c_rd_lat_r;
    else if (cmd.add_c_wr)      add_val = c_wr_lat_r;
    else                        add_val = '0;
    time_nxt = cmd.clr_time ? '0 : time_r + {{(WordW-LatW){1'b0}}, add_val};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else begin
      time_r <= time_nxt;
    end
  end

  // Result register.
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic                is_acc;
  logic [WordW-1:0]    rword;

  assign is_acc = ((kind_r == KIND_READ) || (kind_r == KIND_WRITE)) && !addr_err;
  assign rword  = (is_acc && (kind_r == KIND_READ)) ? data_q_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {5'd0, time_r,
                     (is_acc ? 1'b0 : (!((kind_r == KIND_CLEAR) || (kind_r == KIND_INVAL))
                                        && addr_err)),
                     evict_r & is_acc, hit_r & is_acc, rword};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.kind         = kind_r;
  assign sts.addr_err     = addr_err;
  assign sts.hit          = valid_r[idx] && (tag_q_r == tag);
  assign sts.victim_dirty = valid_r[idx] && dirty_r[idx];
  assign sts.cnt_last     = &cnt_r;
  assign sts.clear_busy   = clr_busy_r;
  assign sts.out_busy     = out_valid_r && !out_tready;

  `DMWC_ASSERT_NXT(a_refill_valid, cmd.tag_wr && !cmd.inval_all, valid_r[idx] && !dirty_r[idx], "refilled line not valid and clean")
  `DMWC_ASSERT_NXT(a_write_dirty, cmd.acc_wr, dirty_r[idx], "written line not dirty")
  `DMWC_ASSERT_IMP(a_no_wb_clearing, clr_busy_r, !cmd.wb_wr && !cmd.rf_rd, "backing access during clearing pass")

endmodule
